>>> design/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console engine: operation and
// command codes, the command that runs from the front end to the back end,
// and the result beat.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QUEUE_DEF   = 4;

  // Row and column index widths that cover the whole parameter range.
  localparam int ROW_W = 7;
  localparam int COL_W = 8;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] BLANK_ATTR = 8'h07;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    logic       cell_written;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } res_t;

  typedef struct packed {
    kind_e            kind;
    logic             blank;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       data_char;
    logic [7:0]       data_attr;
    res_t             res;
  } cmd_t;

endpackage

>>> design/text_console_cursor_scroll_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Text-mode console engine with a ROWS x COLUMNS screen store and a cursor.
//
// The slave stream carries one command per beat, selected by tuser: put a
// character, clear the screen, or read one cell. Every command returns one
// beat on the master stream with the written cell, scroll flag, cursor and
// read data. The configuration channel sets the attribute of put characters.
// Commands pass through a short queue, so the slave side keeps taking beats
// while the back end works or the receiver stalls; a stalled result beat is
// held in the output register.
// At the back end, which has a single memory port, a put or no-op is done
// directly from the queue head, a read goes through a registered memory read,
// a put that scrolls first blanks the new bottom row cell by cell, and a clear
// writes every cell of the store in turn.
// After reset, the screen store is cleared to spaces in attribute 0x07, during
// which tready is low; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF,
  parameter int DEPTH   = tccs_pkg::QUEUE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // char_code[7:0], clear_attr[15:8], read_row[20:16], read_col[27:21]
  input  logic [31:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cell_written[0], cell_row[5:1], cell_col[12:6], cell_char[20:13],
  // cell_attr[28:21], scrolled[29], cursor_row[34:30], cursor_col[41:35],
  // read_char[49:42], read_attr[57:50]
  output logic [63:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  tccs_pkg::cmd_t push_cmd, head_cmd;
  tccs_pkg::res_t res;
  logic           push, pop, full, empty, init_done;

  assign cfg_ready_o = 1'b1;

  tccs_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_data_i   (s_axis_tdata_i),
    .s_user_i   (s_axis_tuser_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .init_done_i(init_done),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tccs_fifo #(
    .DEPTH(DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_cmd),
    .empty_o(empty)
  );

  tccs_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .init_done_o(init_done),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_res_o    (res)
  );

  assign m_axis_tdata_o = {6'b0, res.read_attr, res.read_char, res.cursor_col,
                           res.cursor_row, res.scrolled, res.cell_attr,
                           res.cell_char, res.cell_col, res.cell_row,
                           res.cell_written};

endmodule

>>> design/tccs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_front
// Front end: accepts beats, tracks the cursor and the top-row offset of the
// circular screen store, and turns each beat into a back-end command.
// ----------------------------------------------------------------------------
module tccs_front #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [31:0]      s_data_i,
  input  logic [1:0]       s_user_i,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             init_done_i,
  input  logic             full_i,
  output logic             push_o,
  output tccs_pkg::cmd_t   cmd_o
);

  localparam int RW  = $clog2(ROWS);
  localparam int RW1 = RW + 1;
  localparam int CW  = $clog2(COLUMNS + 1);

  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] top_q, top_d;
  logic [7:0]    attr_q;

  logic [7:0]    ch, fill;
  logic [4:0]    rrow;
  logic [6:0]    rcol;
  logic          is_put, is_read, nl, ordinary, at_last, scroll, in_range;
  logic [RW-1:0] eff_row, base_row, top_sel, prow;
  logic [CW-1:0] eff_col;
  logic [RW1-1:0] sum;

  assign ch   = s_data_i[7:0];
  assign fill = s_data_i[15:8];
  assign rrow = s_data_i[20:16];
  assign rcol = s_data_i[27:21];

  assign s_ready_o = init_done_i && !full_i;
  assign push_o    = s_valid_i && s_ready_o;
  assign at_last   = cur_row_q == RW'(ROWS - 1);
  assign in_range  = (rrow < ROWS) && (rcol < COLUMNS);

  always_comb begin
    is_put   = 1'b0;
    is_read  = 1'b0;
    nl       = 1'b0;
    ordinary = 1'b0;
    unique case (tccs_pkg::op_e'(s_user_i))
      tccs_pkg::OP_PUT: begin
        is_put = 1'b1;
        if (ch == tccs_pkg::CHAR_LF) begin
          nl = 1'b1;
        end else if (ch != tccs_pkg::CHAR_CR) begin
          ordinary = 1'b1;
          nl       = cur_col_q >= CW'(COLUMNS);
        end
      end
      tccs_pkg::OP_READ: is_read = 1'b1;
      default: ;
    endcase

    scroll  = nl && at_last;
    top_d   = top_q;
    if (scroll) begin
      top_d = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
    end
    eff_row = cur_row_q;
    if (nl && !at_last) begin
      eff_row = cur_row_q + 1'b1;
    end
    eff_col = nl ? '0 : cur_col_q;

    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (is_put) begin
      cur_row_d = eff_row;
      cur_col_d = ordinary ? eff_col + 1'b1 : '0;
    end

    base_row = is_read ? RW'(rrow) : eff_row;
    top_sel  = is_read ? top_q : top_d;
    sum      = {1'b0, base_row} + {1'b0, top_sel};
    prow     = (sum >= RW1'(ROWS)) ? RW'(sum - RW1'(ROWS)) : RW'(sum);

    cmd_o           = '0;
    cmd_o.kind      = tccs_pkg::KIND_NONE;
    cmd_o.blank     = scroll;
    cmd_o.row       = tccs_pkg::ROW_W'(prow);
    cmd_o.col       = is_read ? tccs_pkg::COL_W'(rcol) : tccs_pkg::COL_W'(eff_col);
    cmd_o.data_char = ch;
    cmd_o.data_attr = attr_q;
    unique case (tccs_pkg::op_e'(s_user_i))
      tccs_pkg::OP_PUT: begin
        if (ordinary) begin
          cmd_o.kind = tccs_pkg::KIND_WRITE;
        end
      end
      tccs_pkg::OP_CLEAR: begin
        cmd_o.kind      = tccs_pkg::KIND_CLEAR;
        cmd_o.data_attr = fill;
      end
      tccs_pkg::OP_READ: begin
        if (in_range) begin
          cmd_o.kind = tccs_pkg::KIND_READ;
        end
      end
      default: ;
    endcase

    cmd_o.res.cell_written = ordinary;
    if (ordinary) begin
      cmd_o.res.cell_row  = 5'(eff_row);
      cmd_o.res.cell_col  = 7'(eff_col);
      cmd_o.res.cell_char = ch;
      cmd_o.res.cell_attr = attr_q;
    end
    cmd_o.res.scrolled   = scroll;
    cmd_o.res.cursor_row = 5'(cur_row_d);
    cmd_o.res.cursor_col = 7'(cur_col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      top_q     <= '0;
      attr_q    <= tccs_pkg::BLANK_ATTR;
    end else begin
      if (push_o) begin
        cur_row_q <= cur_row_d;
        cur_col_q <= cur_col_d;
        top_q     <= top_d;
      end
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

endmodule

>>> design/tccs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tccs_fifo #(
  parameter int DEPTH = tccs_pkg::QUEUE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tccs_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tccs_pkg::cmd_t data_o,
  output logic           empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tccs_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  count_q;

  assign full_o  = count_q == NW'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = slots[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/tccs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_back
// Back end: owns the screen store, runs the clearing pass after reset, row
// blanking on scroll, full-screen clears, cell writes and reads, and holds
// the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module tccs_back #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tccs_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           init_done_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output tccs_pkg::res_t m_res_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_BLANK, ST_EXEC, ST_CLEAR, ST_DONE
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  tccs_pkg::cmd_t cur_q, cur_d;
  logic           out_valid_q, out_valid_d;
  tccs_pkg::res_t out_q, out_d;

  logic [15:0]    screen_mem [CELLS];
  logic [15:0]    rd_q;
  logic [15:0]    wdata;
  logic           we, re, sweep, out_free;
  logic [tccs_pkg::ROW_W-1:0] row_sel;
  logic [tccs_pkg::COL_W-1:0] col_sel;
  logic [AW-1:0]  addr;

  assign out_free    = !out_valid_q || m_ready_i;
  assign init_done_o = state_q != ST_INIT;
  assign m_valid_o   = out_valid_q;
  assign m_res_o     = out_q;
  assign addr = sweep ? cnt_q : AW'(AW'(row_sel) * AW'(COLUMNS)) + AW'(col_sel);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    sweep       = 1'b0;
    wdata       = {cur_q.data_attr, cur_q.data_char};
    row_sel     = cur_q.row;
    col_sel     = cur_q.col;
    unique case (state_q)
      ST_INIT: begin
        sweep = 1'b1;
        we    = 1'b1;
        wdata = {tccs_pkg::BLANK_ATTR, tccs_pkg::BLANK_CHAR};
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        row_sel = head_i.row;
        col_sel = head_i.col;
        wdata   = {head_i.data_attr, head_i.data_char};
        if (!empty_i) begin
          if (head_i.blank) begin
            pop_o   = 1'b1;
            cur_d   = head_i;
            cnt_d   = '0;
            state_d = ST_BLANK;
          end else begin
            unique case (head_i.kind)
              tccs_pkg::KIND_CLEAR: begin
                pop_o   = 1'b1;
                cur_d   = head_i;
                cnt_d   = '0;
                state_d = ST_CLEAR;
              end
              tccs_pkg::KIND_READ: begin
                pop_o   = 1'b1;
                cur_d   = head_i;
                re      = 1'b1;
                state_d = ST_DONE;
              end
              default: begin
                if (out_free) begin
                  pop_o       = 1'b1;
                  we          = head_i.kind == tccs_pkg::KIND_WRITE;
                  out_valid_d = 1'b1;
                  out_d       = head_i.res;
                end
              end
            endcase
          end
        end
      end
      ST_BLANK: begin
        col_sel = tccs_pkg::COL_W'(cnt_q);
        we      = 1'b1;
        wdata   = {tccs_pkg::BLANK_ATTR, tccs_pkg::BLANK_CHAR};
        if (cnt_q == AW'(COLUMNS - 1)) begin
          cnt_d   = '0;
          state_d = ST_EXEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EXEC: begin
        we      = cur_q.kind == tccs_pkg::KIND_WRITE;
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        sweep = 1'b1;
        we    = 1'b1;
        wdata = {cur_q.data_attr, tccs_pkg::BLANK_CHAR};
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = cur_q.res;
          if (cur_q.kind == tccs_pkg::KIND_READ) begin
            out_d.read_char = rd_q[7:0];
            out_d.read_attr = rd_q[15:8];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_mem[addr] <= wdata;
    end
    if (re) begin
      rd_q <= screen_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

>>> design/tccs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the text console engine, bound to its top level.
// ----------------------------------------------------------------------------
module tccs_checker #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  // A result beat that waits for the receiver holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // The clearing pass keeps the slave side closed right after reset.
  a_init_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  // A written cell leaves the cursor right after it on the same row.
  a_cursor_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      m_axis_tdata_o[41:35] == 7'(m_axis_tdata_o[12:6] + 7'd1) &&
      m_axis_tdata_o[34:30] == m_axis_tdata_o[5:1])
    else $error("cursor does not follow written cell");

  // A scroll always leaves the cursor on the last row.
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[29] |-> m_axis_tdata_o[34:30] == 5'(ROWS - 1))
    else $error("scroll left cursor off the last row");

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console engine. A short directed table
// covers reset contents, out-of-range reads, the unused operation, the
// character extremes, carriage return, pending wrap, newline scrolling and
// both clear extremes. Random phases follow, each with a new text attribute,
// mixing long lines, short lines, reads, clears and noise. Every result beat
// is compared field by field with a table entry or an in-bench model of the screen and cursor.
// ----------------------------------------------------------------------------
module tb_top;
  import tccs_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [7:0] fill;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } console_cmd_t;

  typedef struct packed {
    console_cmd_t cmd;
    int           reps;
    bit           typed;
    res_t         res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;
  logic        cfg_ready_o;

  logic [15:0] screen_model [COLS*ROWS];
  logic [4:0]  cursor_row_q;
  logic [6:0]  cursor_col_q;
  logic [7:0]  text_attr_q;
  res_t        pending_results [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;

  text_console_cursor_scroll_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic advance_line();
    cursor_col_q = '0;
    if (cursor_row_q + 1 >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int c = 0; c < COLS; c++) begin
        screen_model[(ROWS - 1) * COLS + c] = {BLANK_ATTR, BLANK_CHAR};
      end
      cursor_row_q = 5'(ROWS - 1);
      return 1'b1;
    end
    cursor_row_q = cursor_row_q + 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t screen_update(console_cmd_t c);
    res_t        r;
    logic [15:0] rd_word;
    r = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == CHAR_LF) begin
          r.scrolled = advance_line();
        end else if (c.ch == CHAR_CR) begin
          cursor_col_q = '0;
        end else begin
          if (cursor_col_q >= COLS) r.scrolled = advance_line();
          r.cell_written = 1'b1;
          r.cell_row = cursor_row_q;
          r.cell_col = cursor_col_q;
          r.cell_char = c.ch;
          r.cell_attr = text_attr_q;
          screen_model[int'(cursor_row_q) * COLS + int'(cursor_col_q)] = {text_attr_q, c.ch};
          cursor_col_q = cursor_col_q + 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < COLS * ROWS; i++) screen_model[i] = {c.fill, BLANK_CHAR};
      end
      OP_READ: begin
        if (c.rrow < ROWS && c.rcol < COLS) begin
          rd_word = screen_model[int'(c.rrow) * COLS + int'(c.rcol)];
          r.read_char = rd_word[7:0];
          r.read_attr = rd_word[15:8];
        end
      end
      default: ;
    endcase
    r.cursor_row = cursor_row_q;
    r.cursor_col = cursor_col_q;
    return r;
  endfunction

  task automatic send_cmd(input console_cmd_t c, input bit typed, input res_t typed_res);
    res_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, c.rcol, c.rrow, c.fill, c.ch};
    s_axis_tuser <= c.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = screen_update(c);
    pending_results.push_back(typed ? typed_res : pred);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    text_attr_q = value;
  endtask

  function automatic dir_row_t mk(logic [1:0] op, logic [7:0] ch, logic [7:0] fill,
                                  logic [4:0] rrow, logic [6:0] rcol, int reps,
                                  bit typed, res_t res);
    dir_row_t d;
    d.cmd = '{op: op, ch: ch, fill: fill, rrow: rrow, rcol: rcol};
    d.reps = reps;
    d.typed = typed;
    d.res = res;
    return d;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ~m_axis_tready;
      2: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("cell_written", 8'(e.cell_written), 8'(m_axis_tdata_o[0]));
        check_field("cell_row", 8'(e.cell_row), 8'(m_axis_tdata_o[5:1]));
        check_field("cell_col", 8'(e.cell_col), 8'(m_axis_tdata_o[12:6]));
        check_field("cell_char", e.cell_char, m_axis_tdata_o[20:13]);
        check_field("cell_attr", e.cell_attr, m_axis_tdata_o[28:21]);
        check_field("scrolled", 8'(e.scrolled), 8'(m_axis_tdata_o[29]));
        check_field("cursor_row", 8'(e.cursor_row), 8'(m_axis_tdata_o[34:30]));
        check_field("cursor_col", 8'(e.cursor_col), 8'(m_axis_tdata_o[41:35]));
        check_field("read_char", e.read_char, m_axis_tdata_o[49:42]);
        check_field("read_attr", e.read_attr, m_axis_tdata_o[57:50]);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dir_row_t     directed [$];
    console_cmd_t c;
    res_t         blank_read;
    int           n_random;
    int           phase;
    int           style;
    int           lf_weight;
    int           roll;

    for (int i = 0; i < COLS * ROWS; i++) screen_model[i] = {BLANK_ATTR, BLANK_CHAR};
    cursor_row_q = '0;
    cursor_col_q = '0;
    text_attr_q = BLANK_ATTR;
    blank_read = '{read_char: BLANK_CHAR, read_attr: BLANK_ATTR, default: '0};

    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0, 1, 1'b1, blank_read));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd24, 7'd79, 1, 1'b1, blank_read));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd25, 7'd0, 1, 1'b1, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd0, 7'd80, 1, 1'b1, '0));
    directed.push_back(mk(OP_READ, 8'hFF, 8'hFF, 5'd31, 7'd127, 1, 1'b1, '0));
    directed.push_back(mk(OP_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127, 1, 1'b1, '0));
    directed.push_back(mk(OP_PUT, 8'h41, 8'h00, 5'd0, 7'd0, 1, 1'b1,
                          '{cell_written: 1'b1, cell_char: 8'h41, cell_attr: BLANK_ATTR,
                            cursor_col: 7'd1, default: '0}));
    directed.push_back(mk(OP_PUT, 8'h00, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, 8'hFF, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, CHAR_CR, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, 8'h78, 8'h00, 5'd0, 7'd0, COLS, 1'b0, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd0, 7'd79, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, CHAR_CR, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, 8'h79, 8'h00, 5'd0, 7'd0, COLS, 1'b0, '0));
    directed.push_back(mk(OP_PUT, CHAR_LF, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, CHAR_LF, 8'h00, 5'd0, 7'd0, ROWS - 2, 1'b0, '0));
    directed.push_back(mk(OP_PUT, CHAR_LF, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_PUT, 8'h7A, 8'h00, 5'd0, 7'd0, COLS, 1'b0, '0));
    directed.push_back(mk(OP_PUT, 8'h71, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd23, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_CLEAR, 8'h00, 8'hFF, 5'd0, 7'd0, 1, 1'b0, '0));
    directed.push_back(mk(OP_READ, 8'h00, 8'h00, 5'd24, 7'd79, 1, 1'b0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      repeat (directed[i].reps) send_cmd(directed[i].cmd, directed[i].typed, directed[i].res);
    end

    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        0: write_attr(8'h00);
        1: write_attr(8'hFF);
        default: write_attr(8'($urandom_range(0, 255)));
      endcase
      style = $urandom_range(0, 3);
      lf_weight = (style == 0) ? 5 : (style == 1) ? 100 : 40;
      repeat ($urandom_range(40, 160)) begin
        c.op = OP_PUT;
        c.ch = 8'($urandom);
        c.fill = 8'($urandom);
        c.rrow = 5'($urandom);
        c.rcol = 7'($urandom);
        roll = $urandom_range(0, 999);
        if (style == 3) begin
          c.op = 2'($urandom);
          if (c.op == OP_CLEAR && $urandom_range(0, 15) != 0) c.op = OP_READ;
        end else if (roll < 12) begin
          c.op = OP_CLEAR;
        end else if (roll < 180) begin
          c.op = OP_READ;
          if (roll < 165) begin
            c.rrow = ($urandom_range(0, 1) == 0) ? cursor_row_q
                                                 : 5'($urandom_range(0, ROWS - 1));
            c.rcol = 7'($urandom_range(0, COLS - 1));
          end
        end else if (roll < 180 + lf_weight) begin
          c.ch = CHAR_LF;
        end else if (roll < 190 + lf_weight) begin
          c.ch = CHAR_CR;
        end
        send_cmd(c, 1'b0, '0);
        if (c.op != OP_UNUSED) n_random++;
      end
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
